// ===== rtl/core/mpp_pkg.sv =====
// Shared constants, types and helpers for the map point projector.
package mpp_pkg;

    localparam int DEF_DEVICE_WIDTH  = 1280;
    localparam int DEF_DEVICE_HEIGHT = 720;
    localparam int DEF_FRAC_BITS     = 16;

    localparam int CFG_ADDR_W = 6;
    localparam int QUOT_BITS  = 31;

    localparam logic [63:0] RST_CORNER_A = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_CORNER_B = 64'h0000_0000_0001_0000;
    localparam logic [63:0] RST_CORNER_C = 64'h0001_0000_0000_0000;
    localparam logic [63:0] RST_VIEW_MIN = 64'h0000_0000_0000_0000;
    localparam logic [63:0] RST_VIEW_MAX = 64'h0001_0000_0001_0000;

    localparam logic signed [31:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [31:0] S32_MIN = 32'sh8000_0000;
    localparam logic signed [31:0] S31_MIN = 32'sh8000_0001;

    typedef enum logic [2:0] {
        REG_CORNER_A = 3'd0,
        REG_CORNER_B = 3'd1,
        REG_CORNER_C = 3'd2,
        REG_VIEW_MIN = 3'd3,
        REG_VIEW_MAX = 3'd4
    } cfg_reg_t;

    // Context that rides alongside the clamp divider.
    typedef struct packed {
        logic signed [31:0] ux;
        logic signed [31:0] uy;
        logic               clamp;
        logic               degen;
        logic               xdom;
        logic               ydom;
    } clamp_side_t;

    // Difference of two 32-bit values, saturated to +-(2^31-1).
    function automatic logic signed [31:0] sat31_diff(input logic signed [31:0] p,
                                                      input logic signed [31:0] q);
        logic signed [32:0] d;
        d = 33'(p) - 33'(q);
        if (d > 33'sd2147483647) begin
            return S32_MAX;
        end
        if (d < -33'sd2147483647) begin
            return S31_MIN;
        end
        return d[31:0];
    endfunction

endpackage

// ===== rtl/core/mpp_fdiv.sv =====
// Pipelined restoring fixed-point divider, one quotient bit per stage, saturating.
module mpp_fdiv
    import mpp_pkg::*;
#(
    parameter int MAG_W     = 64,
    parameter int FRAC_BITS = DEF_FRAC_BITS,
    parameter int SIDE_W    = 1
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     en,
    input  logic                     in_valid,
    input  logic [MAG_W-1:0]         num_mag,
    input  logic [MAG_W-1:0]         den_mag,
    input  logic                     neg,
    input  logic [SIDE_W-1:0]        in_side,
    output logic                     out_valid,
    output logic signed [31:0]       quot,
    output logic [SIDE_W-1:0]        out_side
);

    localparam int STAGES = QUOT_BITS + 1;

    logic                 valid_reg [STAGES];
    logic [MAG_W-1:0]     rem_reg   [STAGES];
    logic [MAG_W-1:0]     num_reg   [STAGES];
    logic [MAG_W-1:0]     den_reg   [STAGES];
    logic [QUOT_BITS-1:0] q_reg     [STAGES];
    logic                 neg_reg   [STAGES];
    logic                 sat_reg   [STAGES];
    logic [SIDE_W-1:0]    side_reg  [STAGES];
    logic [MAG_W-1:0]     rem0_next;

    // The dividend is num_mag shifted up by FRAC_BITS; its top part seeds the remainder.
    // If that part already reaches the divisor, the quotient overflows 31 bits.
    assign rem0_next = num_mag >> (QUOT_BITS - FRAC_BITS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg[0] <= 1'b0;
        end else if (en) begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= rem0_next;
            num_reg[0]  <= num_mag;
            den_reg[0]  <= den_mag;
            q_reg[0]    <= '0;
            neg_reg[0]  <= neg;
            sat_reg[0]  <= (rem0_next >= den_mag);
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 1; k < STAGES; k++) begin : g_stage
        localparam int J = QUOT_BITS - k;
        logic               xbit;
        logic [MAG_W:0]     trial;
        logic [MAG_W:0]     diff;
        logic               take;
        logic [QUOT_BITS-1:0] q_next;

        if (J >= FRAC_BITS) begin : g_data_bit
            assign xbit = num_reg[k-1][J-FRAC_BITS];
        end else begin : g_zero_bit
            assign xbit = 1'b0;
        end

        assign trial = {rem_reg[k-1], xbit};
        assign take  = (trial >= {1'b0, den_reg[k-1]});
        assign diff  = trial - {1'b0, den_reg[k-1]};

        always_comb begin
            q_next    = q_reg[k-1];
            q_next[J] = take;
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                valid_reg[k] <= 1'b0;
            end else if (en) begin
                valid_reg[k] <= valid_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= take ? diff[MAG_W-1:0] : trial[MAG_W-1:0];
                num_reg[k]  <= num_reg[k-1];
                den_reg[k]  <= den_reg[k-1];
                q_reg[k]    <= q_next;
                neg_reg[k]  <= neg_reg[k-1];
                sat_reg[k]  <= sat_reg[k-1];
                side_reg[k] <= side_reg[k-1];
            end
        end
    end

    always_comb begin
        if (sat_reg[STAGES-1]) begin
            quot = neg_reg[STAGES-1] ? S32_MIN : S32_MAX;
        end else if (neg_reg[STAGES-1]) begin
            quot = -$signed({1'b0, q_reg[STAGES-1]});
        end else begin
            quot = $signed({1'b0, q_reg[STAGES-1]});
        end
    end

    assign out_valid = valid_reg[STAGES-1];
    assign out_side  = side_reg[STAGES-1];

endmodule

// ===== rtl/core/map_point_projector.sv =====
// Top level of the map point projector: configuration, pipeline stages and output register.
//
// Usage: world points (world_x, world_z, Q16.16 signed) enter on the s_ stream with the
// clamp flag in s_tuser. Each point is mapped through the inverse of the frame built from
// corner_a, corner_b and corner_c, optionally pulled back into the unit square, then
// placed in the viewport and scaled to the device raster. Results leave on the m_ stream
// as device_x and device_y, with window_degenerate in m_tuser.
// The block takes one transaction per cycle while the output is not stalled. Each point
// passes the product and determinant stages, the two 32-stage dividers (frame inverse
// and clamp slope, one quotient bit per stage), then the product and scaling stages.
// The user must write the registers through the APB-style port only while no point is in
// flight; the block itself does not enforce this. The derived frame terms are registered.
// Reset clears all valid bits and restores the default frame and viewport.
// When a result waits at the output and m_tready is low, the whole pipeline halts with
// its contents intact; the input stage still takes one more transaction if it is empty.
module map_point_projector
    import mpp_pkg::*;
#(
    parameter int DEVICE_WIDTH  = DEF_DEVICE_WIDTH,
    parameter int DEVICE_HEIGHT = DEF_DEVICE_HEIGHT,
    parameter int FRAC_BITS     = DEF_FRAC_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // world_x [31:0], world_z [63:32]
    input  logic [0:0]            s_tuser,   // clamp_enable [0]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // device_x [31:0], device_y [63:32]
    output logic [0:0]            m_tuser,   // window_degenerate [0]
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [63:0]           pwdata,
    output logic [63:0]           prdata,
    output logic                  pready
);

    localparam logic signed [33:0] ONE  = 34'sd1 <<< FRAC_BITS;
    localparam logic signed [33:0] HALF = ONE >>> 1;
    localparam int DIV2_W  = 35;
    localparam int SIDE2_W = $bits(clamp_side_t);
    localparam int SUM_W   = 65 - FRAC_BITS;
    localparam int PROD_W  = SUM_W + 15;
    localparam logic signed [14:0] DEV_W_S = 15'(DEVICE_WIDTH);
    localparam logic signed [14:0] DEV_H_S = 15'(DEVICE_HEIGHT);
    localparam logic signed [PROD_W-1:0] SAT_HI = PROD_W'(64'sd2147483647);
    localparam logic signed [PROD_W-1:0] SAT_LO = PROD_W'(-64'sd2147483648);

    // ---------------- configuration ----------------
    logic [63:0] corner_a_reg, corner_b_reg, corner_c_reg, view_min_reg, view_max_reg;
    logic        cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel & penable & pwrite;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            corner_a_reg <= RST_CORNER_A;
            corner_b_reg <= RST_CORNER_B;
            corner_c_reg <= RST_CORNER_C;
            view_min_reg <= RST_VIEW_MIN;
            view_max_reg <= RST_VIEW_MAX;
        end else if (cfg_we) begin
            case (cfg_reg_t'(paddr[5:3]))
                REG_CORNER_A: corner_a_reg <= pwdata;
                REG_CORNER_B: corner_b_reg <= pwdata;
                REG_CORNER_C: corner_c_reg <= pwdata;
                REG_VIEW_MIN: view_min_reg <= pwdata;
                REG_VIEW_MAX: view_max_reg <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_reg_t'(paddr[5:3]))
            REG_CORNER_A: prdata = corner_a_reg;
            REG_CORNER_B: prdata = corner_b_reg;
            REG_CORNER_C: prdata = corner_c_reg;
            REG_VIEW_MIN: prdata = view_min_reg;
            REG_VIEW_MAX: prdata = view_max_reg;
            default:      prdata = '0;
        endcase
    end

    logic signed [31:0] ax, ay, mnx, mny;
    assign ax  = $signed(corner_a_reg[31:0]);
    assign ay  = $signed(corner_a_reg[63:32]);
    assign mnx = $signed(view_min_reg[31:0]);
    assign mny = $signed(view_min_reg[63:32]);

    // Frame axes, viewport extent and determinant products follow the registers freely.
    logic signed [31:0] fa_reg, fb_reg, fc_reg, fd_reg, w_reg, h_reg;
    logic signed [63:0] pad_reg, pbc_reg;

    always_ff @(posedge aclk) begin
        fa_reg  <= sat31_diff($signed(corner_b_reg[31:0]), ax);
        fb_reg  <= sat31_diff($signed(corner_b_reg[63:32]), ay);
        fc_reg  <= sat31_diff($signed(corner_c_reg[31:0]), ax);
        fd_reg  <= sat31_diff($signed(corner_c_reg[63:32]), ay);
        w_reg   <= sat31_diff($signed(view_max_reg[31:0]), mnx);
        h_reg   <= sat31_diff($signed(view_max_reg[63:32]), mny);
        pad_reg <= 64'(fa_reg) * 64'(fd_reg);
        pbc_reg <= 64'(fb_reg) * 64'(fc_reg);
    end

    // ---------------- pipeline control ----------------
    logic pipe_en, s1_load;
    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s5_valid_reg;
    logic s6_valid_reg, s7_valid_reg, s8_valid_reg, out_valid_reg;

    assign pipe_en  = !out_valid_reg || m_tready;
    assign s1_load  = pipe_en || !s1_valid_reg;
    assign s_tready = s1_load;

    // ---------------- stage 1: point relative to origin ----------------
    logic signed [31:0] qx1_reg, qy1_reg;
    logic               clamp1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s1_load) begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_load) begin
            qx1_reg    <= sat31_diff($signed(s_tdata[31:0]), ax);
            qy1_reg    <= sat31_diff($signed(s_tdata[63:32]), ay);
            clamp1_reg <= s_tuser[0];
        end
    end

    // ---------------- stage 2: adjugate products ----------------
    logic signed [63:0] pxd_reg, pyc_reg, pya_reg, pxb_reg;
    logic               clamp2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            pxd_reg    <= 64'(qx1_reg) * 64'(fd_reg);
            pyc_reg    <= 64'(qy1_reg) * 64'(fc_reg);
            pya_reg    <= 64'(qy1_reg) * 64'(fa_reg);
            pxb_reg    <= 64'(qx1_reg) * 64'(fb_reg);
            clamp2_reg <= clamp1_reg;
        end
    end

    // ---------------- stage 3: numerators and determinant ----------------
    logic signed [63:0] numx3_reg, numy3_reg, det3_reg;
    logic               clamp3_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s3_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            numx3_reg  <= pxd_reg - pyc_reg;
            numy3_reg  <= pya_reg - pxb_reg;
            det3_reg   <= pad_reg - pbc_reg;
            clamp3_reg <= clamp2_reg;
        end
    end

    // ---------------- frame inverse dividers ----------------
    logic [63:0]        numx_mag, numy_mag, det_mag;
    logic               div1_valid, div1y_valid;
    logic signed [31:0] div1x_quot, div1y_quot;
    logic [0:0]         div1_clamp, div1_degen;

    assign numx_mag = numx3_reg[63] ? 64'(-numx3_reg) : 64'(numx3_reg);
    assign numy_mag = numy3_reg[63] ? 64'(-numy3_reg) : 64'(numy3_reg);
    assign det_mag  = det3_reg[63]  ? 64'(-det3_reg)  : 64'(det3_reg);

    mpp_fdiv #(
        .MAG_W     (64),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (1)
    ) u_div_x (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s3_valid_reg),
        .num_mag   (numx_mag),
        .den_mag   (det_mag),
        .neg       (numx3_reg[63] ^ det3_reg[63]),
        .in_side   (clamp3_reg),
        .out_valid (div1_valid),
        .quot      (div1x_quot),
        .out_side  (div1_clamp)
    );

    mpp_fdiv #(
        .MAG_W     (64),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (1)
    ) u_div_y (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s3_valid_reg),
        .num_mag   (numy_mag),
        .den_mag   (det_mag),
        .neg       (numy3_reg[63] ^ det3_reg[63]),
        .in_side   (det3_reg == 64'sd0),
        .out_valid (div1y_valid),
        .quot      (div1y_quot),
        .out_side  (div1_degen)
    );

    // ---------------- stage 5: dominance decision ----------------
    logic signed [31:0] ux5_next, uy5_next;
    logic signed [33:0] ux_w, uy_w, ox, oy, dnum5_next, dden5_next;
    logic               xdom5_next, ydom5_next, live_clamp;

    logic signed [31:0] ux5_reg, uy5_reg;
    logic signed [33:0] dnum5_reg, dden5_reg;
    logic               clamp5_reg, degen5_reg, xdom5_reg, ydom5_reg;

    always_comb begin
        ux5_next   = div1_degen[0] ? 32'sd0 : div1x_quot;
        uy5_next   = div1_degen[0] ? 32'sd0 : div1y_quot;
        ux_w       = 34'(ux5_next);
        uy_w       = 34'(uy5_next);
        ox         = (ux_w < 0) ? ONE - ux_w : ux_w;
        oy         = (uy_w < 0) ? ONE - uy_w : uy_w;
        // On the centre column only the final clamp applies.
        live_clamp = div1_clamp[0] && (ux_w != HALF);
        xdom5_next = live_clamp && (ox > ONE) && (ox > oy);
        ydom5_next = live_clamp && !xdom5_next && (oy > ONE) && (oy > ox);
        if (xdom5_next) begin
            dnum5_next = uy_w - HALF;
            dden5_next = (ux_w - HALF) <<< 1;
        end else if (ydom5_next) begin
            dnum5_next = ux_w - HALF;
            dden5_next = (uy_w - HALF) <<< 1;
        end else begin
            dnum5_next = '0;
            dden5_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s5_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s5_valid_reg <= div1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ux5_reg    <= ux5_next;
            uy5_reg    <= uy5_next;
            dnum5_reg  <= dnum5_next;
            dden5_reg  <= dden5_next;
            clamp5_reg <= div1_clamp[0];
            degen5_reg <= div1_degen[0];
            xdom5_reg  <= xdom5_next;
            ydom5_reg  <= ydom5_next;
        end
    end

    // ---------------- clamp slope divider ----------------
    logic signed [DIV2_W-1:0] dnum_wide, dden_wide;
    logic [DIV2_W-1:0]        dnum_mag, dden_mag;
    clamp_side_t              side5, side6;
    logic [SIDE2_W-1:0]       side6_bits;
    logic                     div2_valid;
    logic signed [31:0]       slope;

    assign dnum_wide = DIV2_W'(dnum5_reg);
    assign dden_wide = DIV2_W'(dden5_reg);
    assign dnum_mag  = dnum_wide[DIV2_W-1] ? DIV2_W'(-dnum_wide) : DIV2_W'(dnum_wide);
    assign dden_mag  = dden_wide[DIV2_W-1] ? DIV2_W'(-dden_wide) : DIV2_W'(dden_wide);

    always_comb begin
        side5.ux    = ux5_reg;
        side5.uy    = uy5_reg;
        side5.clamp = clamp5_reg;
        side5.degen = degen5_reg;
        side5.xdom  = xdom5_reg;
        side5.ydom  = ydom5_reg;
    end

    mpp_fdiv #(
        .MAG_W     (DIV2_W),
        .FRAC_BITS (FRAC_BITS),
        .SIDE_W    (SIDE2_W)
    ) u_div_clamp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (pipe_en),
        .in_valid  (s5_valid_reg),
        .num_mag   (dnum_mag),
        .den_mag   (dden_mag),
        .neg       (dnum_wide[DIV2_W-1] ^ dden_wide[DIV2_W-1]),
        .in_side   (side5),
        .out_valid (div2_valid),
        .quot      (slope),
        .out_side  (side6_bits)
    );

    assign side6 = clamp_side_t'(side6_bits);

    // ---------------- stage 6: pull back and clamp ----------------
    logic signed [33:0] t_w, uxn, uyn;
    logic signed [31:0] ufx6_next, ufy6_next;
    logic signed [31:0] ufx6_reg, ufy6_reg;
    logic               degen6_reg, clamp6_reg;

    function automatic logic signed [31:0] clamp01(input logic signed [33:0] v);
        if (v < 0) begin
            return 32'sd0;
        end
        if (v > ONE) begin
            return 32'(ONE);
        end
        return v[31:0];
    endfunction

    always_comb begin
        t_w = 34'(slope);
        uxn = 34'(side6.ux);
        uyn = 34'(side6.uy);
        if (side6.xdom) begin
            uyn = HALF + ((34'(side6.ux) > ONE) ? t_w : -t_w);
        end else if (side6.ydom) begin
            uxn = HALF + ((34'(side6.uy) > ONE) ? t_w : -t_w);
        end
        if (side6.clamp) begin
            ufx6_next = clamp01(uxn);
            ufy6_next = clamp01(uyn);
        end else begin
            ufx6_next = side6.ux;
            ufy6_next = side6.uy;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s6_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s6_valid_reg <= div2_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            ufx6_reg   <= ufx6_next;
            ufy6_reg   <= ufy6_next;
            degen6_reg <= side6.degen;
            clamp6_reg <= side6.clamp;
        end
    end

    // ---------------- stage 7: viewport extent products ----------------
    logic signed [63:0] px7_reg, py7_reg;
    logic               degen7_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s7_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s7_valid_reg <= s6_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            px7_reg    <= 64'(ufx6_reg) * 64'(w_reg);
            py7_reg    <= 64'(ufy6_reg) * 64'(h_reg);
            degen7_reg <= degen6_reg;
        end
    end

    // ---------------- stage 8: back to fixed point plus viewport origin ----------------
    logic signed [SUM_W-1:0] sx8_reg, sy8_reg;
    logic                    degen8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s8_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            s8_valid_reg <= s7_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            sx8_reg    <= SUM_W'($signed(px7_reg[63:FRAC_BITS])) + SUM_W'(mnx);
            sy8_reg    <= SUM_W'($signed(py7_reg[63:FRAC_BITS])) + SUM_W'(mny);
            degen8_reg <= degen7_reg;
        end
    end

    // ---------------- output register: raster scaling and saturation ----------------
    logic signed [PROD_W-1:0] mx, my;
    logic signed [31:0]       dx_next, dy_next;
    logic signed [31:0]       dx_reg, dy_reg;
    logic                     degen_out_reg;

    always_comb begin
        mx = PROD_W'(sx8_reg) * PROD_W'(DEV_W_S);
        my = PROD_W'(sy8_reg) * PROD_W'(DEV_H_S);
        if (mx > SAT_HI) begin
            dx_next = S32_MAX;
        end else if (mx < SAT_LO) begin
            dx_next = S32_MIN;
        end else begin
            dx_next = mx[31:0];
        end
        if (my > SAT_HI) begin
            dy_next = S32_MAX;
        end else if (my < SAT_LO) begin
            dy_next = S32_MIN;
        end else begin
            dy_next = my[31:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (pipe_en) begin
            out_valid_reg <= s8_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (pipe_en) begin
            dx_reg        <= dx_next;
            dy_reg        <= dy_next;
            degen_out_reg <= degen8_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {dy_reg, dx_reg};
    assign m_tuser  = degen_out_reg;

    // ---------------- assertions ----------------
    a_div_lanes_aligned : assert property (@(posedge aclk) disable iff (!aresetn)
        div1_valid == div1y_valid)
        else $error("frame divider lanes out of step");

    a_div_to_stage5 : assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_en && div1_valid |=> s5_valid_reg)
        else $error("frame divider result dropped before the dominance stage");

    a_degen_zero : assert property (@(posedge aclk) disable iff (!aresetn)
        s5_valid_reg && degen5_reg |-> ux5_reg == 32'sd0 && uy5_reg == 32'sd0)
        else $error("degenerate frame did not give a zero unit point");

    a_clamp_range : assert property (@(posedge aclk) disable iff (!aresetn)
        s6_valid_reg && clamp6_reg |-> ufx6_reg >= 32'sd0 && ufx6_reg <= 32'(ONE)
                                    && ufy6_reg >= 32'sd0 && ufy6_reg <= 32'(ONE))
        else $error("clamped unit point outside the unit square");

endmodule
